// File: hw/rtl/fpd_pkg.sv
`default_nettype none

package fpd_pkg;

	localparam int MAX_NODES = 4096;
	localparam int MAX_EDGES = 4095;
	localparam int MAX_ROWS  = 2048;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int ROW_W   = $clog2(MAX_ROWS);

	localparam int LEN_W   = 32;
	localparam int SUM_W   = 48;
	localparam int EPOCH_W = 8;

	localparam int EDGE_CNT_W = 12;
	localparam int TIP_CNT_W  = 13;
	localparam int ROW_CNT_W  = 12;

	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 56;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	typedef enum logic [1:0] {
		CMD_LOAD_EDGE = 2'd0,
		CMD_LOAD_MAP  = 2'd1,
		CMD_MARK      = 2'd2,
		CMD_COMPUTE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ROW_RANGE   = 2'd1,
		ST_TIP_INVALID = 2'd2
	} status_t;

	localparam logic [1:0] REG_EDGE_COUNT = 2'd0;
	localparam logic [1:0] REG_TIP_COUNT  = 2'd1;
	localparam logic [1:0] REG_ROW_COUNT  = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0] child;
		logic [NODE_W-1:0] parent;
		logic [LEN_W-1:0]  len;
	} edge_t;

endpackage

`default_nettype wire

// File: hw/rtl/faith_phylo_diversity.sv
`default_nettype none

// Faith's phylogenetic diversity of one sample. Each input word carries a command in s_tuser:
// load an edge (by postorder rank), load a row-to-tip map entry, mark an observed taxon row, or
// compute. Every accepted word returns exactly one result word (status and sum). A load goes
// straight to the result; a mark reads the row-to-tip map, then checks the row and tip and writes
// presence. A compute walks the edges in rank order: each edge needs one edge-table read followed
// by one presence-memory read and a conditional write at the parent, so the presence memory port
// sets the pace. Presence is tagged with an 8-bit sample mark, so a compute clears the sample at
// once; after reset, and after every 255th compute, a clearing pass sweeps all 4096 presence
// entries and s_tready stays low meanwhile. Configuration registers (edge_count at 0x0, tip_count
// at 0x4, row_count at 0x8) should be written only while no word is in flight.
module faith_phylo_diversity (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// edge_rank, child_node, parent_node, edge_length, map_row, tip_index, taxon_row, pad
	input  logic [fpd_pkg::S_DATA_W-1:0]   s_tdata,
	// cmd
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, pd_sum, pad
	output logic [fpd_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fpd_pkg::CFG_AW-1:0]     paddr,
	input  logic [fpd_pkg::CFG_DW-1:0]     pwdata,
	output logic [fpd_pkg::CFG_DW-1:0]     prdata,
	output logic                           pready
);
	import fpd_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_MARK   = 6'b000100,
		S_EDGE_A = 6'b001000,
		S_EDGE_B = 6'b010000,
		S_FIN    = 6'b100000
	} fsm_t;

	fsm_t                   state_q;
	logic [EDGE_CNT_W-1:0]  edge_count_q;
	logic [TIP_CNT_W-1:0]   tip_count_q;
	logic [ROW_CNT_W-1:0]   row_count_q;

	logic [EDGE_CNT_W-1:0]  n_q;
	logic [EDGE_CNT_W-1:0]  rank_q;
	logic [EDGE_CNT_W-1:0]  rank_nx;
	logic [EDGE_CNT_W-1:0]  n_clamp;
	logic [NODE_W-1:0]      clr_cnt_q;
	logic [EPOCH_W-1:0]     epoch_q;
	logic                   clr_pend_q;
	logic                   epoch_wrap;
	logic [NODE_W-1:0]      parent_q;
	logic [LEN_W-1:0]       len_q;
	logic [ROW_W-1:0]       row_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W:0]         sum_add;
	logic [SUM_W-1:0]       sum_nx;
	status_t                status_q;
	status_t                mark_status;

	logic                   m_tvalid_q;
	status_t                m_status_q;
	logic [SUM_W-1:0]       m_sum_q;

	cmd_t                   cmd;
	logic [EDGE_AW-1:0]     in_rank;
	logic [NODE_W-1:0]      in_child;
	logic [NODE_W-1:0]      in_parent;
	logic [LEN_W-1:0]       in_len;
	logic [ROW_W-1:0]       in_map_row;
	logic [NODE_W-1:0]      in_tip;
	logic [ROW_W-1:0]       in_taxon;
	logic                   accept;
	logic                   out_free;
	logic                   cfg_we;
	logic                   present;

	edge_t                  edge_mem [MAX_EDGES];
	edge_t                  edge_rd_q;
	logic                   edge_we;
	logic                   edge_re;
	logic [EDGE_AW-1:0]     edge_ra;

	logic [NODE_W-1:0]      row_mem [MAX_ROWS];
	logic [NODE_W-1:0]      row_rd_q;
	logic                   row_we;
	logic                   row_re;

	logic [EPOCH_W-1:0]     pres_mem [MAX_NODES];
	logic [EPOCH_W-1:0]     pres_rd_q;
	logic                   pres_we;
	logic [NODE_W-1:0]      pres_wa;
	logic [EPOCH_W-1:0]     pres_wd;
	logic                   pres_re;

	assign cmd        = cmd_t'(s_tuser);
	assign in_rank    = s_tdata[11:0];
	assign in_child   = s_tdata[23:12];
	assign in_parent  = s_tdata[35:24];
	assign in_len     = s_tdata[67:36];
	assign in_map_row = s_tdata[78:68];
	assign in_tip     = s_tdata[90:79];
	assign in_taxon   = s_tdata[101:91];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W - SUM_W - 2){1'b0}}, m_sum_q, m_status_q};

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_EDGE_COUNT: prdata = CFG_DW'(edge_count_q);
			REG_TIP_COUNT:  prdata = CFG_DW'(tip_count_q);
			REG_ROW_COUNT:  prdata = CFG_DW'(row_count_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			tip_count_q  <= '0;
			row_count_q  <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_EDGE_COUNT: edge_count_q <= pwdata[EDGE_CNT_W-1:0];
				REG_TIP_COUNT:  tip_count_q  <= pwdata[TIP_CNT_W-1:0];
				REG_ROW_COUNT:  row_count_q  <= pwdata[ROW_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// datapath helpers
	assign rank_nx    = rank_q + EDGE_CNT_W'(1);
	assign n_clamp    = (edge_count_q > EDGE_CNT_W'(MAX_EDGES)) ? EDGE_CNT_W'(MAX_EDGES)
	                                                             : edge_count_q;
	assign epoch_wrap = (epoch_q == {EPOCH_W{1'b1}});
	assign present    = (pres_rd_q == epoch_q);
	assign sum_add    = {1'b0, sum_q} + (SUM_W + 1)'(len_q);
	assign sum_nx     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

	always_comb begin
		if ({1'b0, row_q} >= row_count_q) begin
			mark_status = ST_ROW_RANGE;
		end else if ({1'b0, row_rd_q} >= tip_count_q) begin
			mark_status = ST_TIP_INVALID;
		end else begin
			mark_status = ST_OK;
		end
	end

	// memory port control
	assign edge_we = accept && (cmd == CMD_LOAD_EDGE) && (in_rank < EDGE_AW'(MAX_EDGES));
	assign row_we  = accept && (cmd == CMD_LOAD_MAP) &&
	                 ({1'b0, in_map_row} < (ROW_W + 1)'(MAX_ROWS));
	assign row_re  = accept && (cmd == CMD_MARK);
	assign pres_re = (state_q == S_EDGE_A);

	always_comb begin
		edge_re = 1'b0;
		edge_ra = '0;
		if (accept && (cmd == CMD_COMPUTE)) begin
			edge_re = 1'b1;
		end else if (state_q == S_EDGE_A) begin
			// fetch the next edge while this one waits on presence
			edge_re = (rank_nx < n_q);
			edge_ra = rank_nx[EDGE_AW-1:0];
		end
	end

	always_comb begin
		pres_we = 1'b0;
		pres_wa = '0;
		pres_wd = epoch_q;
		case (state_q)
			S_CLEAR: begin
				pres_we = 1'b1;
				pres_wa = clr_cnt_q;
				pres_wd = '0;
			end
			S_MARK: begin
				pres_we = (mark_status == ST_OK);
				pres_wa = row_rd_q;
			end
			S_EDGE_B: begin
				pres_we = present;
				pres_wa = parent_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[in_rank] <= '{child: in_child, parent: in_parent, len: in_len};
		end
		if (edge_re) begin
			edge_rd_q <= edge_mem[edge_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[in_map_row] <= in_tip;
		end
		if (row_re) begin
			row_rd_q <= row_mem[in_taxon];
		end
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_wa] <= pres_wd;
		end
		if (pres_re) begin
			pres_rd_q <= pres_mem[edge_rd_q.child];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_EDGE_A) begin
			parent_q <= edge_rd_q.parent;
			len_q    <= edge_rd_q.len;
		end
		if (accept) begin
			row_q <= in_taxon;
		end
		if (state_q == S_FIN && out_free) begin
			m_status_q <= status_q;
			m_sum_q    <= sum_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			epoch_q    <= EPOCH_W'(1);
			clr_pend_q <= 1'b0;
			n_q        <= '0;
			rank_q     <= '0;
			sum_q      <= '0;
			status_q   <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + NODE_W'(1);
					if (clr_cnt_q == NODE_W'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						sum_q    <= '0;
						status_q <= ST_OK;
						rank_q   <= '0;
						n_q      <= n_clamp;
						case (cmd)
							CMD_MARK: state_q <= S_MARK;
							CMD_COMPUTE: begin
								if (n_clamp == '0) begin
									// empty walk: retire the sample straight away
									state_q    <= S_FIN;
									clr_pend_q <= epoch_wrap;
									epoch_q    <= epoch_wrap ? EPOCH_W'(1)
									                         : epoch_q + EPOCH_W'(1);
								end else begin
									state_q <= S_EDGE_A;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_MARK: begin
					status_q <= mark_status;
					state_q  <= S_FIN;
				end
				S_EDGE_A: begin
					state_q <= S_EDGE_B;
				end
				S_EDGE_B: begin
					if (present) begin
						sum_q <= sum_nx;
					end
					if (rank_nx == n_q) begin
						state_q    <= S_FIN;
						clr_pend_q <= epoch_wrap;
						epoch_q    <= epoch_wrap ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
					end else begin
						rank_q  <= rank_nx;
						state_q <= S_EDGE_A;
					end
				end
				S_FIN: begin
					if (out_free) begin
						clr_pend_q <= 1'b0;
						clr_cnt_q  <= '0;
						state_q    <= clr_pend_q ? S_CLEAR : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/fpd_checker.sv
`default_nettype none

module fpd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [fpd_pkg::M_DATA_W-1:0]   m_tdata
);
	import fpd_pkg::*;

	logic [1:0]       chk_status;
	logic [SUM_W-1:0] chk_sum;

	assign chk_status = m_tdata[1:0];
	assign chk_sum    = m_tdata[SUM_W+1:2];

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// an error status never carries a sum
	a_err_no_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (chk_status == ST_ROW_RANGE || chk_status == ST_TIP_INVALID)
		|-> chk_sum == '0)
		else $error("error status with non-zero sum");

	// every accepted word takes the block out of idle, so ready drops
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready held after accepting a word");

	// presence sweep runs straight after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready)
		else $error("ready during presence sweep");

endmodule

bind faith_phylo_diversity fpd_checker u_fpd_checker (.*);

`default_nettype wire
